// File: design/bqf_pkg.sv
// Shared types and constants for the biquad IIR filter.
// Used by bqf_ctrl, bqf_mac and biquad_iir_filter_top; no dependencies.
package bqf_pkg;

   localparam int GUARD_BITS = 9;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FF_ONE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FF_TWO  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_ONE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_TWO  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FF1,
      ST_FF2,
      ST_SCALE,
      ST_GAIN,
      ST_FB1,
      ST_FB2,
      ST_DONE
   } bqf_state_type;

   typedef enum logic [2:0] {
      SEL_FF1,
      SEL_FF2,
      SEL_GAIN,
      SEL_FB1,
      SEL_FB2
   } bqf_sel_type;

   typedef struct packed {
      logic        idle;
      logic        load;
      logic        acc_load;
      logic        step;
      logic        neg;
      logic        msb;
      logic        commit;
      bqf_sel_type sel;
   } bqf_ctl_type;

endpackage

// File: design/bqf_mac.sv
// Bit-serial multiply-accumulate unit: multiplier bits shift out LSB first,
// multiplicand shifts left, one conditional add per cycle while ctl.step is high. Uses bqf_pkg.
module bqf_mac import bqf_pkg::*; #(
   parameter int ACC_W = 65,
   parameter int OP_W  = 31
) (
   input  logic             clock,
   input  bqf_ctl_type      ctl,
   input  logic [ACC_W-1:0] mcand_load,
   input  logic [OP_W-1:0]  mplr_load,
   input  logic [ACC_W-1:0] acc_init,
   output logic [ACC_W-1:0] acc_out
);

   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0] mcand_ff, mcand_in;
   logic [OP_W-1:0]  mplr_ff, mplr_in;
   logic [ACC_W-1:0] addend;
   logic             sub;

   always_comb begin
      sub    = ctl.neg ^ ctl.msb;
      addend = mplr_ff[0] ? mcand_ff : '0;
      if (ctl.acc_load) begin
         acc_in = acc_init;
      end else if (ctl.step) begin
         acc_in = acc_ff + (sub ? ~addend : addend) + ACC_W'(sub);
      end else begin
         acc_in = acc_ff;
      end
      if (ctl.load) begin
         mcand_in = mcand_load;
         mplr_in  = mplr_load;
      end else if (ctl.step) begin
         mcand_in = {mcand_ff[ACC_W-2:0], 1'b0};
         mplr_in  = {1'b0, mplr_ff[OP_W-1:1]};
      end else begin
         mcand_in = mcand_ff;
         mplr_in  = mplr_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      mplr_ff  <= mplr_in;
   end

   assign acc_out = acc_ff;

endmodule

// File: design/bqf_ctrl.sv
// Sequencer for the biquad: steps the serial MAC through the five products,
// the intermediate rounding and the final commit. Uses bqf_pkg.
module bqf_ctrl import bqf_pkg::*; #(
   parameter int SW   = 16,
   parameter int OP_W = 31
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        out_free,
   output bqf_ctl_type ctl
);

   localparam int CNT_W = $clog2(OP_W);

   bqf_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             last;

   assign last = (state_ff == ST_GAIN) ? (cnt_ff == CNT_W'(OP_W - 1))
                                       : (cnt_ff == CNT_W'(SW - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_FF1;
         ST_FF1:   if (last) state_in = ST_FF2;
         ST_FF2:   if (last) state_in = ST_SCALE;
         ST_SCALE: state_in = ST_GAIN;
         ST_GAIN:  if (last) state_in = ST_FB1;
         ST_FB1:   if (last) state_in = ST_FB2;
         ST_FB2:   if (last) state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl = '{idle: 1'b0, load: 1'b0, acc_load: 1'b0, step: 1'b0, neg: 1'b0,
              msb: 1'b0, commit: 1'b0, sel: SEL_FF1};
      case (state_ff)
         ST_IDLE: begin
            ctl.idle     = 1'b1;
            ctl.load     = req_tvalid;
            ctl.acc_load = req_tvalid;
            ctl.sel      = SEL_FF1;
         end
         ST_FF1: begin
            ctl.step = 1'b1;
            ctl.msb  = last;
            ctl.load = last;
            ctl.sel  = SEL_FF2;
         end
         ST_FF2: begin
            ctl.step = 1'b1;
            ctl.msb  = last;
         end
         ST_SCALE: begin
            ctl.load     = 1'b1;
            ctl.acc_load = 1'b1;
            ctl.sel      = SEL_GAIN;
         end
         ST_GAIN: begin
            ctl.step = 1'b1;
            ctl.msb  = last;
            ctl.load = last;
            ctl.sel  = SEL_FB1;
         end
         ST_FB1: begin
            ctl.step = 1'b1;
            ctl.neg  = 1'b1;
            ctl.msb  = last;
            ctl.load = last;
            ctl.sel  = SEL_FB2;
         end
         ST_FB2: begin
            ctl.step = 1'b1;
            ctl.neg  = 1'b1;
            ctl.msb  = last;
         end
         ST_DONE: begin
            ctl.commit = out_free;
         end
         default: begin
            ctl.idle = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (ctl.step && !last) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else begin
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// File: design/biquad_iir_filter_top.sv
// Biquad IIR filter, direct form I, with a bit-serial datapath.
// Depends on bqf_pkg, bqf_ctrl and bqf_mac.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_tvalid/tready   | tdata: sample_in
//   rsp     | out       | rsp_tvalid/tready   | tdata: sample_out, tuser: clipped
//   csr     | in        | csr_we              | csr_index, csr_wdata
//
// Each transaction runs the one-bit-per-cycle MAC through four SAMPLE_WIDTH-bit
// products and one SAMPLE_WIDTH+15-bit product in turn; the next sample is
// accepted only after the previous result has been committed.
// Reset is synchronous; it restores the coefficients and clears the history.
// A result waiting on rsp does not block the next accept; only a second
// finished result waits in the final state until the output register frees.
module biquad_iir_filter_top import bqf_pkg::*; #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    req_tdata,  // sample_in
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    rsp_tdata,  // sample_out
   output logic                                 rsp_tuser,  // clipped
   input  logic                                 csr_we,
   input  logic [CSR_IDX_W-1:0]                 csr_index,
   input  logic [COEF_WIDTH-1:0]                csr_wdata
);

   localparam int SW    = SAMPLE_WIDTH;
   localparam int CW    = COEF_WIDTH;
   localparam int CF    = CW - 4;
   localparam int S_SH  = CF - GUARD_BITS;
   localparam int OP_W  = SW + 6 + GUARD_BITS;
   localparam int ACC_W = CW + SW + 8 + GUARD_BITS;
   localparam int QW    = ACC_W - CF - GUARD_BITS;
   localparam int DW    = ((SW + 7) / 8) * 8;

   localparam logic [CW-1:0]    GAIN_ONE = CW'(1) << CF;
   localparam logic [ACC_W-1:0] S_HALF   = ACC_W'(1) << (S_SH - 1);
   localparam logic [ACC_W-1:0] F_HALF   = ACC_W'(1) << (CF + GUARD_BITS - 1);
   localparam logic [SW-1:0]    Y_MAX    = {1'b0, {(SW-1){1'b1}}};
   localparam logic [SW-1:0]    Y_MIN    = {1'b1, {(SW-1){1'b0}}};

   bqf_ctl_type      ctl;
   logic [ACC_W-1:0] acc;
   logic [ACC_W-1:0] acc_init, mcand_load;
   logic [OP_W-1:0]  mplr_load;

   logic [CW-1:0] gain_ff, gain_in, b1_ff, b1_in, b2_ff, b2_in;
   logic [CW-1:0] a1_ff, a1_in, a2_ff, a2_in;
   logic [SW-1:0] x0_ff, x0_in, x1_ff, x1_in, x2_ff, x2_in;
   logic [SW-1:0] y1_ff, y1_in, y2_ff, y2_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_data_ff, rsp_data_in;
   logic          rsp_clip_ff, rsp_clip_in;

   logic [ACC_W-1:0] s_sum, f_sum;
   logic [OP_W-1:0]  s_round;
   logic [QW-1:0]    q;
   logic [SW-1:0]    y_sat;
   logic             y_clip;
   logic             out_free;
   logic [SW-1:0]    req_sample;

   assign req_sample = req_tdata[SW-1:0];
   assign out_free   = !rsp_valid_ff || rsp_tready;

   bqf_ctrl #(
      .SW   (SW),
      .OP_W (OP_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .out_free   (out_free),
      .ctl        (ctl)
   );

   bqf_mac #(
      .ACC_W (ACC_W),
      .OP_W  (OP_W)
   ) u_mac (
      .clock      (clock),
      .ctl        (ctl),
      .mcand_load (mcand_load),
      .mplr_load  (mplr_load),
      .acc_init   (acc_init),
      .acc_out    (acc)
   );

   // intermediate rounding of the feedforward sum, and final rounding and saturation
   always_comb begin
      s_sum   = acc + S_HALF;
      s_round = s_sum[S_SH +: OP_W];
      f_sum   = acc + F_HALF;
      q       = f_sum[ACC_W-1 -: QW];
      if ((&q[QW-1:SW-1]) || !(|q[QW-1:SW-1])) begin
         y_sat  = q[SW-1:0];
         y_clip = 1'b0;
      end else begin
         y_sat  = q[QW-1] ? Y_MIN : Y_MAX;
         y_clip = 1'b1;
      end
   end

   always_comb begin
      acc_init = ctl.idle ? {{(ACC_W-SW-CF){req_sample[SW-1]}}, req_sample, {CF{1'b0}}}
                          : '0;
      case (ctl.sel)
         SEL_FF1: begin
            mcand_load = {{(ACC_W-CW){b1_ff[CW-1]}}, b1_ff};
            mplr_load  = {{(OP_W-SW){x1_ff[SW-1]}}, x1_ff};
         end
         SEL_FF2: begin
            mcand_load = {{(ACC_W-CW){b2_ff[CW-1]}}, b2_ff};
            mplr_load  = {{(OP_W-SW){x2_ff[SW-1]}}, x2_ff};
         end
         SEL_GAIN: begin
            mcand_load = {{(ACC_W-CW){gain_ff[CW-1]}}, gain_ff};
            mplr_load  = s_round;
         end
         SEL_FB1: begin
            mcand_load = {{(ACC_W-CW-GUARD_BITS){a1_ff[CW-1]}}, a1_ff, {GUARD_BITS{1'b0}}};
            mplr_load  = {{(OP_W-SW){y1_ff[SW-1]}}, y1_ff};
         end
         SEL_FB2: begin
            mcand_load = {{(ACC_W-CW-GUARD_BITS){a2_ff[CW-1]}}, a2_ff, {GUARD_BITS{1'b0}}};
            mplr_load  = {{(OP_W-SW){y2_ff[SW-1]}}, y2_ff};
         end
         default: begin
            mcand_load = '0;
            mplr_load  = '0;
         end
      endcase
   end

   always_comb begin
      gain_in = gain_ff;
      b1_in   = b1_ff;
      b2_in   = b2_ff;
      a1_in   = a1_ff;
      a2_in   = a2_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GAIN:   gain_in = csr_wdata;
            CSR_FF_ONE: b1_in   = csr_wdata;
            CSR_FF_TWO: b2_in   = csr_wdata;
            CSR_FB_ONE: a1_in   = csr_wdata;
            CSR_FB_TWO: a2_in   = csr_wdata;
            default:    gain_in = gain_ff;
         endcase
      end
   end

   always_comb begin
      x0_in        = (ctl.idle && req_tvalid) ? req_sample : x0_ff;
      x1_in        = ctl.commit ? x0_ff : x1_ff;
      x2_in        = ctl.commit ? x1_ff : x2_ff;
      y1_in        = ctl.commit ? y_sat : y1_ff;
      y2_in        = ctl.commit ? y1_ff : y2_ff;
      rsp_data_in  = ctl.commit ? y_sat : rsp_data_ff;
      rsp_clip_in  = ctl.commit ? y_clip : rsp_clip_ff;
      rsp_valid_in = ctl.commit ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_ONE;
         b1_ff        <= '0;
         b2_ff        <= '0;
         a1_ff        <= '0;
         a2_ff        <= '0;
         x1_ff        <= '0;
         x2_ff        <= '0;
         y1_ff        <= '0;
         y2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gain_ff      <= gain_in;
         b1_ff        <= b1_in;
         b2_ff        <= b2_in;
         a1_ff        <= a1_in;
         a2_ff        <= a2_in;
         x1_ff        <= x1_in;
         x2_ff        <= x2_in;
         y1_ff        <= y1_in;
         y2_ff        <= y2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff       <= x0_in;
      rsp_data_ff <= rsp_data_in;
      rsp_clip_ff <= rsp_clip_in;
   end

   assign req_tready = ctl.idle;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DW'(rsp_data_ff);
   assign rsp_tuser  = rsp_clip_ff;

   a_no_accept_mid_item: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && ctl.step))
      else $error("input accepted while the MAC is stepping");

   a_commit_slot_free: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result committed over an untaken result");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |=> (rsp_tvalid && rsp_tuser == $past(y_clip)))
      else $error("committed result not presented");

   a_clip_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_data_ff == Y_MAX || rsp_data_ff == Y_MIN))
      else $error("clipped result not at a limit");

endmodule

// File: sim/bqf_response_checker.sv
// Checker for the biquad IIR filter: watches the req, rsp and csr ports, predicts each
// filtered sample with exact wide arithmetic and compares it with the rsp transaction.
// Depends on bqf_pkg for the register indexes and the guard width.
module bqf_response_checker import bqf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [15:0]          req_tdata,   // sample_in
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [15:0]          rsp_tdata,   // sample_out
   input  logic                 rsp_tuser,   // clipped
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata,
   output int                   fail_count,
   output int                   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC    = 28;
   localparam logic signed [127:0] Y_MAX = 32767;
   localparam logic signed [127:0] Y_MIN = -32768;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               clipped;
   } filt_out_type;

   logic signed [31:0] gain, ff_one, ff_two, fb_one, fb_two;
   logic signed [15:0] x_d1, x_d2, y_d1, y_d2;
   filt_out_type       filtered_q[$];

   function automatic filt_out_type run_biquad(input logic signed [15:0] x);
      logic signed [127:0] xw, acc, fb;
      filt_out_type r;
      xw  = x;
      acc = (xw <<< FRAC) + ff_one * x_d1 + ff_two * x_d2;
      acc = (acc + (128'sd1 <<< (FRAC - GUARD_BITS - 1))) >>> (FRAC - GUARD_BITS);
      fb  = fb_one * y_d1 + fb_two * y_d2;
      acc = gain * acc - (fb <<< GUARD_BITS);
      acc = (acc + (128'sd1 <<< (FRAC + GUARD_BITS - 1))) >>> (FRAC + GUARD_BITS);
      if (acc > Y_MAX) begin
         r.sample  = 16'sh7fff;
         r.clipped = 1'b1;
      end else if (acc < Y_MIN) begin
         r.sample  = 16'sh8000;
         r.clipped = 1'b1;
      end else begin
         r.sample  = acc[15:0];
         r.clipped = 1'b0;
      end
      x_d2 = x_d1;
      x_d1 = x;
      y_d2 = y_d1;
      y_d1 = r.sample;
      return r;
   endfunction

   always @(posedge clock) begin
      filt_out_type want;
      if (reset) begin
         gain   = 32'sh1000_0000;
         ff_one = '0;
         ff_two = '0;
         fb_one = '0;
         fb_two = '0;
         x_d1   = '0;
         x_d2   = '0;
         y_d1   = '0;
         y_d2   = '0;
         filtered_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GAIN:   gain   = csr_wdata;
               CSR_FF_ONE: ff_one = csr_wdata;
               CSR_FF_TWO: ff_two = csr_wdata;
               CSR_FB_ONE: fb_one = csr_wdata;
               CSR_FB_TWO: fb_two = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (filtered_q.size() == 0) begin
               $display("%0t ns: unexpected result: expected none, actual %0d clipped %b",
                        $time, $signed(rsp_tdata), rsp_tuser);
               fail_count++;
            end else begin
               want = filtered_q.pop_front();
               if (rsp_tdata !== want.sample) begin
                  $display("%0t ns: sample_out mismatch: expected %0d, actual %0d",
                           $time, want.sample, $signed(rsp_tdata));
                  fail_count++;
               end
               if (rsp_tuser !== want.clipped) begin
                  $display("%0t ns: clipped mismatch: expected %b, actual %b",
                           $time, want.clipped, rsp_tuser);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            filtered_q.push_back(run_biquad(req_tdata));
      end
      outstanding = filtered_q.size();
   end

endmodule

// File: sim/tb_biquad_iir_filter_top.sv
// Testbench top for biquad_iir_filter_top: drives samples and coefficient writes,
// throttles the result channel and reports the verdict.
// Depends on bqf_pkg, the filter RTL and bqf_response_checker.
module tb_biquad_iir_filter_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bqf_pkg::*;

   typedef struct packed {
      logic [31:0] gain;
      logic [31:0] ff_one;
      logic [31:0] ff_two;
      logic [31:0] fb_one;
      logic [31:0] fb_two;
   } coef_set_t;

   typedef enum {COEF_WILD, COEF_STABLE, COEF_FIR} coef_style_t;
   typedef enum {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} sink_mode_t;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [15:0]          req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [15:0]          rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_wdata;
   int                   fail_count;
   int                   outstanding;
   bit                   hold_rsp = 1'b0;

   biquad_iir_filter_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   bqf_response_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tb_biquad_iir_filter_top failed");
      $finish;
   end

   function automatic int signed_span(input int lim);
      return int'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   function automatic logic [15:0] pick_sample();
      logic [15:0] v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0:       v = 16'h7fff;
               1:       v = 16'h8000;
               2:       v = 16'h0000;
               default: v = 16'hffff;
            endcase
         end
         1, 2:    v = 16'(signed_span(300));
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   function automatic coef_set_t random_coefs(input coef_style_t style);
      coef_set_t c;
      int a2, lim;
      case (style)
         COEF_WILD: c = {$urandom, $urandom, $urandom, $urandom, $urandom};
         COEF_FIR: begin
            c.gain   = signed_span(1 << 29);
            c.ff_one = signed_span(1 << 29);
            c.ff_two = signed_span(1 << 28);
            c.fb_one = '0;
            c.fb_two = '0;
         end
         default: begin
            // keep the poles inside the stability triangle
            a2       = int'($urandom_range(0, 255 << 20)) - (1 << 27);
            lim      = ((1 << 28) + a2) / 16 * 15;
            c.gain   = signed_span(1 << 28);
            c.ff_one = signed_span(1 << 29);
            c.ff_two = signed_span(1 << 28);
            c.fb_one = signed_span(lim);
            c.fb_two = a2;
         end
      endcase
      return c;
   endfunction

   task automatic push_sample(input logic [15:0] x);
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_run(input int count, input bit no_idle);
      int burst_left, gap;
      burst_left = 0;
      for (int n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (no_idle)
               gap = 0;
            else if ($urandom_range(0, 1) == 0)
               gap = $urandom_range(0, 3);
            else
               gap = $urandom_range(1, 130);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         push_sample(pick_sample());
         burst_left--;
      end
   endtask

   task automatic drain();
      wait (outstanding == 0);
      @(negedge clock);
   endtask

   task automatic program_filter(input coef_set_t c);
      logic [31:0]          vals [5];
      logic [CSR_IDX_W-1:0] regs [5];
      vals = '{c.gain, c.ff_one, c.ff_two, c.fb_one, c.fb_two};
      regs = '{CSR_GAIN, CSR_FF_ONE, CSR_FF_TWO, CSR_FB_ONE, CSR_FB_TWO};
      for (int i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(negedge clock);
      end
      // index past the last register: must leave every coefficient alone
      csr_we    <= 1'b1;
      csr_index <= CSR_FB_TWO + CSR_IDX_W'($urandom_range(1, 3));
      csr_wdata <= $urandom;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      sink_mode_t mode;
      int seg_len;
      rsp_tready = 1'b0;
      forever begin
         mode    = sink_mode_t'($urandom_range(0, 3));
         seg_len = $urandom_range(20, 300);
         for (int c = 0; c < seg_len; c++) begin
            @(negedge clock);
            if (hold_rsp) begin
               rsp_tready <= 1'b0;
               repeat (599) @(negedge clock);
               hold_rsp = 1'b0;
            end else begin
               case (mode)
                  SINK_OPEN:   rsp_tready <= 1'b1;
                  SINK_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
                  SINK_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
                  default:     rsp_tready <= (c % 3 == 0);
               endcase
            end
         end
      end
   end

   initial begin
      coef_style_t style;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset coefficients: unity pass-through
      push_sample(16'h0000);
      push_sample(16'h7fff);
      push_sample(16'h8000);
      push_sample(16'h0001);
      push_sample(16'hffff);
      push_sample(16'h5555);
      push_sample(16'haaaa);
      req_tvalid <= 1'b0;
      drain();

      // largest gain: saturate both ways
      program_filter(coef_set_t'{32'h7fff_ffff, 32'h0, 32'h0, 32'h0, 32'h0});
      push_sample(16'h7fff);
      push_sample(16'h8000);
      push_sample(16'h1000);
      push_sample(16'hf000);
      push_sample(16'h0000);
      req_tvalid <= 1'b0;
      drain();

      // all coefficients at alternating extremes
      program_filter(coef_set_t'{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                                 32'h7fff_ffff, 32'h8000_0000});
      push_sample(16'h7fff);
      push_sample(16'h8000);
      push_sample(16'h7fff);
      push_sample(16'h0064);
      push_sample(16'h0000);
      req_tvalid <= 1'b0;
      drain();

      // extreme feedback: clamped output circulates
      program_filter(coef_set_t'{32'h1000_0000, 32'h0, 32'h0, 32'h8000_0000, 32'h7fff_ffff});
      push_sample(16'h0001);
      push_sample(16'h0000);
      push_sample(16'h0000);
      push_sample(16'h0000);
      push_sample(16'h8000);
      req_tvalid <= 1'b0;
      drain();

      // half gain: rounding ties go toward plus infinity
      program_filter(coef_set_t'{32'h0800_0000, 32'h0, 32'h0, 32'h0, 32'h0});
      push_sample(16'h0001);
      push_sample(16'hffff);
      push_sample(16'h0003);
      req_tvalid <= 1'b0;
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0:       style = COEF_WILD;
            2:       style = COEF_FIR;
            default: style = COEF_STABLE;
         endcase
         program_filter(random_coefs(style));
         if (phase == 2)
            hold_rsp = 1'b1;
         if (phase == 5) begin
            send_run(64, 1'b1);
            req_tvalid <= 1'b0;
            drain();
            send_run(64, 1'b1);
         end else begin
            send_run(128, 1'b0);
         end
         req_tvalid <= 1'b0;
         drain();
      end

      repeat (300) @(negedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("tb_biquad_iir_filter_top passed");
      else
         $display("tb_biquad_iir_filter_top failed");
      $finish;
   end

endmodule
